FILE: rtl/pfm_pkg.sv
// Shared constants and types for the prime field Montgomery ALU.
package pfm_pkg;

  localparam int unsigned LIMB_W = 64;
  localparam int unsigned FE_W   = 256;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned DIG_W  = 32;
  localparam int unsigned NDIG   = FE_W / DIG_W;

  localparam int unsigned MUL_LAT  = 5;
  localparam int unsigned MSUB_LAT = 2;
  localparam int unsigned TOT_LAT  = 3 * MUL_LAT + 1 + MSUB_LAT;
  localparam int unsigned PHI_DLY  = 2 * MUL_LAT;
  localparam int unsigned AS_DLY   = TOT_LAT - 1 - MSUB_LAT;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_TO   = 3'd3,
    OP_FROM = 3'd4
  } op_e;

  localparam logic [FE_W-1:0] P_MOD =
    256'h30644E72E131A029_B85045B68181585D_2833E84879B97091_43E1F593F0000001;
  localparam logic [FE_W-1:0] R2_MOD =
    256'h0216D0B17F4E44A5_8C49833D53BB8085_53FE3AB1E35C59E3_1BB8E645AE216DA7;

  // -v^-1 mod 2^256 by Newton iteration, elaboration only
  function automatic logic [FE_W-1:0] neg_inv(input logic [FE_W-1:0] v);
    logic [FE_W-1:0] x;
    x = v;
    for (int k = 0; k < 8; k++) begin
      x = x * (FE_W'(2) - v * x);
    end
    return -x;
  endfunction

  localparam logic [FE_W-1:0] NPINV = neg_inv(P_MOD);

endpackage

FILE: rtl/pfm_in_if.sv
// Input channel: op code and two four-limb operands.
interface pfm_in_if import pfm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [LIMB_W-1:0] a_limb0;
  logic [LIMB_W-1:0] a_limb1;
  logic [LIMB_W-1:0] a_limb2;
  logic [LIMB_W-1:0] a_limb3;
  logic [LIMB_W-1:0] b_limb0;
  logic [LIMB_W-1:0] b_limb1;
  logic [LIMB_W-1:0] b_limb2;
  logic [LIMB_W-1:0] b_limb3;

  modport source (output valid, op, a_limb0, a_limb1, a_limb2, a_limb3,
                  b_limb0, b_limb1, b_limb2, b_limb3, input ready);
  modport sink   (input valid, op, a_limb0, a_limb1, a_limb2, a_limb3,
                  b_limb0, b_limb1, b_limb2, b_limb3, output ready);
endinterface

FILE: rtl/pfm_out_if.sv
// Output channel: four-limb field result.
interface pfm_out_if import pfm_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [LIMB_W-1:0] res_limb0;
  logic [LIMB_W-1:0] res_limb1;
  logic [LIMB_W-1:0] res_limb2;
  logic [LIMB_W-1:0] res_limb3;

  modport source (output valid, res_limb0, res_limb1, res_limb2, res_limb3,
                  input ready);
  modport sink   (input valid, res_limb0, res_limb1, res_limb2, res_limb3,
                  output ready);
endinterface

FILE: rtl/pfm_mul.sv
// Pipelined 256 x 256 multiplier: 32x32 partial products and a registered adder tree.
module pfm_mul import pfm_pkg::*; #(
  parameter int unsigned OUT_W = 512
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [FE_W-1:0]  a_i,
  input  logic [FE_W-1:0]  b_i,
  output logic [OUT_W-1:0] prod_o
);

  localparam int unsigned PW = 2 * FE_W;

  logic [2*DIG_W-1:0] pp_q [NDIG][NDIG];
  logic [OUT_W-1:0]   term [2*NDIG];
  logic [OUT_W-1:0]   l1_q [8];
  logic [OUT_W-1:0]   l2_q [4];
  logic [OUT_W-1:0]   l3_q [2];
  logic [OUT_W-1:0]   prod_q;

  // even and odd digit products of a row do not overlap: concatenate
  always_comb begin
    logic [FE_W-1:0] ev;
    logic [FE_W-1:0] od;
    for (int i = 0; i < NDIG; i++) begin
      for (int j = 0; j < NDIG / 2; j++) begin
        ev[2*DIG_W*j +: 2*DIG_W] = pp_q[i][2*j];
        od[2*DIG_W*j +: 2*DIG_W] = pp_q[i][2*j+1];
      end
      term[2*i]   = OUT_W'(PW'(ev) << (DIG_W * i));
      term[2*i+1] = OUT_W'(PW'(od) << (DIG_W * (i + 1)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NDIG; i++) begin
        for (int j = 0; j < NDIG; j++) begin
          pp_q[i][j] <= a_i[DIG_W*i +: DIG_W] * b_i[DIG_W*j +: DIG_W];
        end
      end
      for (int k = 0; k < 8; k++) l1_q[k] <= term[2*k] + term[2*k+1];
      for (int k = 0; k < 4; k++) l2_q[k] <= l1_q[2*k] + l1_q[2*k+1];
      for (int k = 0; k < 2; k++) l3_q[k] <= l2_q[2*k] + l2_q[2*k+1];
      prod_q <= l3_q[0] + l3_q[1];
    end
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/pfm_modsub.sv
// Two-stage x - y with p added back on borrow, top carry dropped.
module pfm_modsub import pfm_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [FE_W-1:0] x_i,
  input  logic [FE_W-1:0] y_i,
  output logic [FE_W-1:0] r_o
);

  logic [FE_W:0]   t_q;
  logic [FE_W-1:0] r_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q <= {1'b0, x_i} - {1'b0, y_i};
      r_q <= t_q[FE_W-1:0] + (t_q[FE_W] ? P_MOD : '0);
    end
  end

  assign r_o = r_q;

endmodule

FILE: rtl/prime_field_montgomery_alu_top.sv
// Top level of the prime field Montgomery ALU.
//
//  channel  dir  payload                              beat
//  in_i     in   op, a_limb0..3, b_limb0..3           valid & ready
//  out_o    out  res_limb0..3                         valid & ready
//
// One beat per cycle sustained while out_o is ready; every op shares one pipeline depth from input to output,
// set by three 5-stage multipliers (a*b, m = low*(-p^-1), m*p), one add and a
// 2-stage modular subtract. All stages move together; a held output stalls the
// whole pipe and in_i.ready drops, nothing is lost. Reset clears only valid bits.
module prime_field_montgomery_alu_top import pfm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfm_in_if.sink    in_i,
  pfm_out_if.source out_o
);

  logic               en;
  logic               fire;
  logic [TOT_LAT-1:0] vld_q;
  logic [FE_W-1:0]    a;
  logic [FE_W-1:0]    b;
  logic [FE_W-1:0]    bm;
  logic [2*FE_W-1:0]  prod;
  logic [FE_W-1:0]    m;
  logic [2*FE_W-1:0]  mp;
  logic [FE_W-1:0]    phi_q [PHI_DLY];
  logic [PHI_DLY-1:0] nz_q;
  logic [FE_W-1:0]    u_q;
  logic [FE_W-1:0]    mres;
  logic [FE_W-1:0]    xs_q;
  logic [FE_W-1:0]    ys_q;
  logic [FE_W-1:0]    asr;
  logic [FE_W-1:0]    as_q [AS_DLY];
  logic [OP_W-1:0]    op_q [TOT_LAT];
  logic [FE_W-1:0]    res;

  assign en         = !vld_q[TOT_LAT-1] || out_o.ready;
  assign in_i.ready = en;
  assign fire       = in_i.valid && en;

  assign a = {in_i.a_limb3, in_i.a_limb2, in_i.a_limb1, in_i.a_limb0};
  assign b = {in_i.b_limb3, in_i.b_limb2, in_i.b_limb1, in_i.b_limb0};

  always_comb begin
    unique case (in_i.op)
      OP_TO:   bm = R2_MOD;
      OP_FROM: bm = FE_W'(1);
      default: bm = b;
    endcase
  end

  pfm_mul #(.OUT_W(2 * FE_W)) u_mul_ab (
    .clk_i, .en_i(en), .a_i(a), .b_i(bm), .prod_o(prod)
  );

  pfm_mul #(.OUT_W(FE_W)) u_mul_m (
    .clk_i, .en_i(en), .a_i(prod[FE_W-1:0]), .b_i(NPINV), .prod_o(m)
  );

  pfm_mul #(.OUT_W(2 * FE_W)) u_mul_mp (
    .clk_i, .en_i(en), .a_i(m), .b_i(P_MOD), .prod_o(mp)
  );

  // low halves of prod + m*p sum to 0 or 2^256: carry iff prod low is nonzero
  always_ff @(posedge clk_i) begin
    if (en) begin
      phi_q[0] <= prod[2*FE_W-1:FE_W];
      nz_q[0]  <= |prod[FE_W-1:0];
      for (int k = 1; k < PHI_DLY; k++) begin
        phi_q[k] <= phi_q[k-1];
        nz_q[k]  <= nz_q[k-1];
      end
      u_q <= phi_q[PHI_DLY-1] + mp[2*FE_W-1:FE_W] + FE_W'(nz_q[PHI_DLY-1]);
    end
  end

  pfm_modsub u_msub_mul (
    .clk_i, .en_i(en), .x_i(u_q), .y_i(P_MOD), .r_o(mres)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (in_i.op == OP_ADD) begin
        xs_q <= a + b;
        ys_q <= P_MOD;
      end else begin
        xs_q <= a;
        ys_q <= b;
      end
      as_q[0] <= asr;
      for (int k = 1; k < AS_DLY; k++) as_q[k] <= as_q[k-1];
      op_q[0] <= in_i.op;
      for (int k = 1; k < TOT_LAT; k++) op_q[k] <= op_q[k-1];
    end
  end

  pfm_modsub u_msub_as (
    .clk_i, .en_i(en), .x_i(xs_q), .y_i(ys_q), .r_o(asr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT_LAT-2:0], fire};
    end
  end

  always_comb begin
    unique case (op_q[TOT_LAT-1])
      OP_ADD, OP_SUB:        res = as_q[AS_DLY-1];
      OP_MUL, OP_TO, OP_FROM: res = mres;
      default:               res = '0;
    endcase
  end

  assign out_o.valid     = vld_q[TOT_LAT-1];
  assign out_o.res_limb0 = res[0*LIMB_W +: LIMB_W];
  assign out_o.res_limb1 = res[1*LIMB_W +: LIMB_W];
  assign out_o.res_limb2 = res[2*LIMB_W +: LIMB_W];
  assign out_o.res_limb3 = res[3*LIMB_W +: LIMB_W];

endmodule

FILE: tb/sv/pfm_tb_if.sv
`timescale 1ns / 1ps
// Testbench copies of the ALU channel interfaces are not needed; this file holds the request beat record type.
package pfm_tb_pkg;
  import pfm_pkg::*;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [FE_W-1:0]   a;
    logic [FE_W-1:0]   b;
  } alu_req_t;
endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the prime field Montgomery ALU: random and corner beats, field-level prediction.
module testbench;
  import pfm_pkg::*;
  import pfm_tb_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   n_in;
  int   n_out;
  int   op_seen [8];

  pfm_in_if  in_ch ();
  pfm_out_if out_ch ();

  prime_field_montgomery_alu_top uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always begin
    clk_i = 1'b0; #1;
    clk_i = 1'b1; #1;
  end

  alu_req_t        pending_q[$];
  logic [FE_W-1:0] expected_q[$];

  // x - y, p added back on borrow, carry dropped
  function automatic logic [FE_W-1:0] field_sub(logic [FE_W-1:0] x, logic [FE_W-1:0] y);
    logic [FE_W:0] d;
    d = {1'b0, x} - {1'b0, y};
    return d[FE_W] ? d[FE_W-1:0] + P_MOD : d[FE_W-1:0];
  endfunction

  function automatic logic [FE_W-1:0] mont_product(logic [FE_W-1:0] x, logic [FE_W-1:0] y);
    logic [2*FE_W-1:0] t;
    logic [FE_W+LIMB_W-1:0] row;
    logic [LIMB_W-1:0] k;
    logic [LIMB_W-1:0] ninv;
    logic              c2;
    logic [LIMB_W:0]   top;
    ninv = 64'hc2e1f593efffffff;
    t = {256'd0, x} * {256'd0, y};
    c2 = 1'b0;
    for (int i = 0; i < 4; i++) begin
      k = t[64*i +: 64] * ninv;
      row = {64'd0, t[64*i +: 256]} + {64'd0, P_MOD} * k;
      t[64*i +: 256] = row[255:0];
      top = {1'b0, t[64*(i+4) +: 64]} + row[319:256] + c2;
      t[64*(i+4) +: 64] = top[63:0];
      c2 = top[64];
    end
    return field_sub(t[511:256], P_MOD);
  endfunction

  function automatic logic [FE_W-1:0] alu_result(alu_req_t r);
    case (r.op)
      OP_ADD:  return field_sub(r.a + r.b, P_MOD);
      OP_SUB:  return field_sub(r.a, r.b);
      OP_MUL:  return mont_product(r.a, r.b);
      OP_TO:   return mont_product(r.a, R2_MOD);
      OP_FROM: return mont_product(r.a, 256'd1);
      default: return '0;
    endcase
  endfunction

  task automatic report(string what, logic [FE_W-1:0] got, logic [FE_W-1:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic logic [FE_W-1:0] rand_fe(int kind);
    logic [FE_W-1:0] v;
    v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    case (kind)
      0: return v % P_MOD;
      1: return '0;
      2: return '1;
      3: return P_MOD - 1;
      4: return P_MOD;
      5: return 256'd1;
      default: return v;
    endcase
  endfunction

  function automatic alu_req_t make_req(logic [OP_W-1:0] op, logic [FE_W-1:0] a,
                                        logic [FE_W-1:0] b);
    alu_req_t r;
    r.op = op; r.a = a; r.b = b;
    return r;
  endfunction

  initial begin
    logic [2:0] op;
    int kind_a;
    int kind_b;
    for (int o = 0; o < 8; o++) begin
      pending_q.push_back(make_req(o[2:0], '0, '0));
      pending_q.push_back(make_req(o[2:0], '1, '1));
      pending_q.push_back(make_req(o[2:0], P_MOD - 1, P_MOD - 1));
    end
    pending_q.push_back(make_req(OP_SUB, '0, 256'd1));
    for (int n = 0; n < 1400; n++) begin
      op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      kind_a = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
      kind_b = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 6);
      pending_q.push_back(make_req(op, rand_fe(kind_a), rand_fe(kind_b)));
    end
  end

  int in_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      {in_ch.op, in_ch.a_limb0, in_ch.a_limb1, in_ch.a_limb2, in_ch.a_limb3} <= '0;
      {in_ch.b_limb0, in_ch.b_limb1, in_ch.b_limb2, in_ch.b_limb3} <= '0;
      in_gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else begin
      if (in_ch.valid) begin
        expected_q.push_back(alu_result(make_req(in_ch.op,
          {in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0},
          {in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0})));
        op_seen[in_ch.op]++;
        n_in++;
      end
      if (in_gap > 0 || pending_q.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (in_gap > 0) in_gap <= in_gap - 1;
      end else begin
        alu_req_t r;
        r = pending_q.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.op <= r.op;
        {in_ch.a_limb3, in_ch.a_limb2, in_ch.a_limb1, in_ch.a_limb0} <= r.a;
        {in_ch.b_limb3, in_ch.b_limb2, in_ch.b_limb1, in_ch.b_limb0} <= r.b;
        in_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
      end
    end
  end

  int out_gap;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        logic [FE_W-1:0] got;
        int              gap;
        got = {out_ch.res_limb3, out_ch.res_limb2, out_ch.res_limb1, out_ch.res_limb0};
        n_out++;
        if (expected_q.size() == 0) begin
          report("unexpected beat", got, '0);
        end else begin
          logic [FE_W-1:0] want;
          want = expected_q.pop_front();
          if (got[63:0] !== want[63:0]) report("res_limb0", got, want);
          if (got[127:64] !== want[127:64]) report("res_limb1", got, want);
          if (got[191:128] !== want[191:128]) report("res_limb2", got, want);
          if (got[255:192] !== want[255:192]) report("res_limb3", got, want);
        end
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
        out_gap <= gap;
        out_ch.ready <= (gap == 0);
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    errors = 0; n_in = 0; n_out = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_q.size() == 0 && !in_ch.valid && expected_q.size() == 0);
    repeat (TOT_LAT + 20) @(posedge clk_i);
    $display("covered %0d beats in, %0d out; add %0d sub %0d mul %0d to %0d from %0d",
             n_in, n_out, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4]);
    $display("unused op codes %0d, corner operands zero, all-ones, p-1, p",
             op_seen[5] + op_seen[6] + op_seen[7]);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule
